@@ rtl/sfe_pkg.sv @@
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared types and constants for the stereo feedback echo: sample and gain
// types, register indexes and stream payload widths.
// ----------------------------------------------------------------------------
`default_nettype none

package sfe_pkg;

  // Q1.23 sample and Q0.15 gain
  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 15;
  localparam int DELAY_W  = 17;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [GAIN_W-1:0]   gain_t;

  localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
  localparam sample_t SAMPLE_MIN = 24'sh800000;

  // gains handed from the register file to the channel datapaths
  typedef struct packed {
    gain_t fb;
    gain_t wet;
    gain_t dry;
  } gain_set_t;

  // configuration port; indexes above the last register are ignored
  localparam int CFG_AW = 3;
  localparam int CFG_DW = DELAY_W;

  localparam logic [CFG_AW-1:0] REG_DELAY_LENGTH  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_FEEDBACK_GAIN = 3'd1;
  localparam logic [CFG_AW-1:0] REG_WET_GAIN      = 3'd2;
  localparam logic [CFG_AW-1:0] REG_DRY_GAIN      = 3'd3;

  // register reset values
  localparam int    DELAY_RST = 12000;
  localparam gain_t FB_RST    = 15'd2621;
  localparam gain_t WET_RST   = 15'd9175;
  localparam gain_t DRY_RST   = 15'd29557;

  // history depth default
  localparam int DEPTH_DEF = 131072;

  // stream payload: two samples, left in the low bits
  localparam int FRAME_W = 2 * SAMPLE_W;

endpackage

`default_nettype wire

@@ rtl/sfe_ram.sv @@
// ----------------------------------------------------------------------------
// sfe_ram
// Generic simple dual-port RAM: one write port, one read port with a read
// enable and registered read data (read-first on an address collision).
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 131072
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/sfe_cfg.sv @@
// ----------------------------------------------------------------------------
// sfe_cfg
// Register file for the echo: delay length (clamped to 1..DEPTH-1 as it is
// written) and the three Q0.15 gains.
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_cfg #(
  parameter int DEPTH = sfe_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [sfe_pkg::CFG_AW-1:0]    cfg_addr,
  input  wire logic [sfe_pkg::CFG_DW-1:0]    cfg_wdata,
  output      logic [$clog2(DEPTH)-1:0]      delay,
  output      sfe_pkg::gain_set_t            gains
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = (AW > sfe_pkg::DELAY_W) ? AW : sfe_pkg::DELAY_W;
  localparam logic [CW-1:0] DMAX = CW'(DEPTH - 1);
  localparam int DLY_RST_I = (sfe_pkg::DELAY_RST > DEPTH - 1) ? DEPTH - 1
                                                              : sfe_pkg::DELAY_RST;
  localparam logic [AW-1:0] DLY_RST = AW'(DLY_RST_I);

  logic [AW-1:0]        delay_r, delay_nxt;
  sfe_pkg::gain_set_t   gains_r, gains_nxt;
  logic [CW-1:0]        dly_ext;
  logic [AW-1:0]        dly_clamped;

  // clamp the written delay to 1..DEPTH-1
  always_comb begin
    dly_ext = CW'(cfg_wdata[sfe_pkg::DELAY_W-1:0]);
    if (dly_ext == '0) begin
      dly_clamped = AW'(1);
    end else if (dly_ext > DMAX) begin
      dly_clamped = AW'(DMAX);
    end else begin
      dly_clamped = AW'(dly_ext);
    end
  end

  // decode the register index
  always_comb begin
    delay_nxt = delay_r;
    gains_nxt = gains_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        sfe_pkg::REG_DELAY_LENGTH:  delay_nxt     = dly_clamped;
        sfe_pkg::REG_FEEDBACK_GAIN: gains_nxt.fb  = cfg_wdata[sfe_pkg::GAIN_W-1:0];
        sfe_pkg::REG_WET_GAIN:      gains_nxt.wet = cfg_wdata[sfe_pkg::GAIN_W-1:0];
        sfe_pkg::REG_DRY_GAIN:      gains_nxt.dry = cfg_wdata[sfe_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r     <= DLY_RST;
      gains_r.fb  <= sfe_pkg::FB_RST;
      gains_r.wet <= sfe_pkg::WET_RST;
      gains_r.dry <= sfe_pkg::DRY_RST;
    end else begin
      delay_r <= delay_nxt;
      gains_r <= gains_nxt;
    end
  end

  assign delay = delay_r;
  assign gains = gains_r;

endmodule

`default_nettype wire

@@ rtl/sfe_chan.sv @@
// ----------------------------------------------------------------------------
// sfe_chan
// One channel of the echo datapath: output mix dry*x + wet*delayed and the
// history value x + fb*delayed, each rounded half up and saturated to Q1.23.
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_chan (
  input  wire sfe_pkg::sample_t   x,
  input  wire sfe_pkg::sample_t   delayed,
  input  wire sfe_pkg::gain_set_t gains,
  output      sfe_pkg::sample_t   y,
  output      sfe_pkg::sample_t   store
);

  logic signed [39:0] p_dry, p_wet, p_fb;
  logic signed [40:0] acc, acc_rnd;
  logic signed [39:0] fb_rnd;
  logic signed [25:0] y_q;
  logic signed [24:0] fb_q;
  logic signed [25:0] store_q;

  function automatic sfe_pkg::sample_t sat(input logic signed [25:0] v);
    sfe_pkg::sample_t r;
    if (v > 26'(sfe_pkg::SAMPLE_MAX)) begin
      r = sfe_pkg::SAMPLE_MAX;
    end else if (v < 26'(sfe_pkg::SAMPLE_MIN)) begin
      r = sfe_pkg::SAMPLE_MIN;
    end else begin
      r = sfe_pkg::sample_t'(v);
    end
    return r;
  endfunction

  // Q1.23 x Q0.15 products
  assign p_dry = $signed({1'b0, gains.dry}) * x;
  assign p_wet = $signed({1'b0, gains.wet}) * delayed;
  assign p_fb  = $signed({1'b0, gains.fb})  * delayed;

  // output mix: full-precision sum, add half, floor shift
  assign acc     = 41'(p_dry) + 41'(p_wet);
  assign acc_rnd = acc + 41'sd16384;
  assign y_q     = 26'(acc_rnd >>> 15);
  assign y       = sat(y_q);

  // feedback into history
  assign fb_rnd  = p_fb + 40'sd16384;
  assign fb_q    = 25'(fb_rnd >>> 15);
  assign store_q = 26'(fb_q) + 26'(x);
  assign store   = sat(store_q);

endmodule

`default_nettype wire

@@ rtl/stereo_feedback_echo_core.sv @@
// ----------------------------------------------------------------------------
// stereo_feedback_echo_core
// Feedback delay echo on stereo Q1.23 frames with a circular history per
// channel.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one stereo frame per request, left sample in tdata[23:0], right
//           in tdata[47:24]. out_* : the echoed frame in the same layout.
//   cfg_* : write delay length and the three Q0.15 gains while idle.
// Timing
//   A frame accepted into the compute-stage registers moves on into the output
//   register when that register is empty or being taken.
//   One frame per clock is sustained while out_tready is high: the history read
//   is issued at accept, the mix is formed in the compute stage and the history
//   is written as the frame leaves it. With a delay of one, the previous frame's
//   stored value is forwarded from a register; the loop is multiply, add, saturate.
// Reset
//   Clears the write position and the pipeline; registers take their reset
//   values. History entries not yet written since reset read as zero, known
//   from the write position and a wrap flag, so there is no clearing sweep.
// Stall
//   When out_tready is low the result holds; one more frame may sit in the
//   compute stage, after that in_tready drops until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_feedback_echo_core #(
  parameter int DEPTH = sfe_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input frames
  input  wire logic                          in_tvalid,
  output      logic                          in_tready,
  input  wire logic [sfe_pkg::FRAME_W-1:0]   in_tdata,   // left_in, right_in
  // output frames
  output      logic                          out_tvalid,
  input  wire logic                          out_tready,
  output      logic [sfe_pkg::FRAME_W-1:0]   out_tdata,  // left_out, right_out
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [sfe_pkg::CFG_AW-1:0]    cfg_addr,
  input  wire logic [sfe_pkg::CFG_DW-1:0]    cfg_wdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = sfe_pkg::SAMPLE_W;

  logic [AW-1:0]       delay;
  sfe_pkg::gain_set_t  gains;

  logic                accept, s1_go;
  logic [AW-1:0]       rd_addr;
  logic [AW:0]         rd_wide;
  logic [AW-1:0]       wp_inc;

  logic                s1_valid_r, s1_valid_nxt;
  sfe_pkg::sample_t    xl_r, xr_r;
  logic [AW-1:0]       wa_r;
  logic                fwd_r, zero_r;
  logic [AW-1:0]       wp_r, wp_nxt;
  logic                wrapped_r, wrapped_nxt;
  sfe_pkg::sample_t    last_l_r, last_r_r;
  logic                out_valid_r, out_valid_nxt;
  sfe_pkg::sample_t    out_l_r, out_r_r;

  logic [SW-1:0]       hist_l, hist_r;
  sfe_pkg::sample_t    dly_l, dly_r;
  sfe_pkg::sample_t    y_l, y_r, st_l, st_r;

  sfe_cfg #(.DEPTH(DEPTH)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .delay     (delay),
    .gains     (gains)
  );

  // handshake: compute stage drains into the output register
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign accept    = in_tvalid && in_tready;

  // read address wp - delay, modulo DEPTH
  always_comb begin
    if (wp_r >= delay) begin
      rd_wide = (AW+1)'(wp_r) - (AW+1)'(delay);
    end else begin
      rd_wide = (AW+1)'(wp_r) + (AW+1)'(DEPTH) - (AW+1)'(delay);
    end
    rd_addr = rd_wide[AW-1:0];
  end

  // advance and wrap the write position
  assign wp_inc = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);

  always_comb begin
    wp_nxt      = wp_r;
    wrapped_nxt = wrapped_r;
    if (accept) begin
      wp_nxt = wp_inc;
      if (wp_r == AW'(DEPTH - 1)) begin
        wrapped_nxt = 1'b1;
      end
    end
  end

  assign s1_valid_nxt  = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_go ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      wp_r        <= wp_nxt;
      wrapped_r   <= wrapped_nxt;
    end
  end

  // capture the request; flag forwarding and never-written entries
  always_ff @(posedge clk) begin
    if (accept) begin
      xl_r   <= sfe_pkg::sample_t'(in_tdata[SW-1:0]);
      xr_r   <= sfe_pkg::sample_t'(in_tdata[2*SW-1:SW]);
      wa_r   <= wp_r;
      fwd_r  <= (delay == AW'(1)) && s1_valid_r;
      zero_r <= !wrapped_r && (wp_r < delay);
    end
  end

  // hold the last stored values for the delay-of-one case and load the output samples
  always_ff @(posedge clk) begin
    if (s1_go) begin
      last_l_r <= st_l;
      last_r_r <= st_r;
      out_l_r  <= y_l;
      out_r_r  <= y_r;
    end
  end

  sfe_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_hist_l (
    .clk   (clk),
    .we    (s1_go),
    .waddr (wa_r),
    .wdata (st_l),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (hist_l)
  );

  sfe_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_hist_r (
    .clk   (clk),
    .we    (s1_go),
    .waddr (wa_r),
    .wdata (st_r),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (hist_r)
  );

  // select the delayed sample
  always_comb begin
    if (fwd_r) begin
      dly_l = last_l_r;
      dly_r = last_r_r;
    end else if (zero_r) begin
      dly_l = '0;
      dly_r = '0;
    end else begin
      dly_l = sfe_pkg::sample_t'(hist_l);
      dly_r = sfe_pkg::sample_t'(hist_r);
    end
  end

  sfe_chan u_chan_l (
    .x       (xl_r),
    .delayed (dly_l),
    .gains   (gains),
    .y       (y_l),
    .store   (st_l)
  );

  sfe_chan u_chan_r (
    .x       (xr_r),
    .delayed (dly_r),
    .gains   (gains),
    .y       (y_r),
    .store   (st_r)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r_r, out_l_r};

  // a frame leaving the compute stage always lands in the output register
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid_r)
    else $error("compute stage drained without loading output");

  // an empty compute stage never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled with empty compute stage");

  // once the history has wrapped it stays fully written
  a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    wrapped_r |=> wrapped_r)
    else $error("wrap flag dropped");

  // write position steps by one per accepted request
  a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (wp_r == (($past(wp_r) == AW'(DEPTH - 1)) ? '0 : $past(wp_r) + AW'(1))))
    else $error("write position did not advance");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stereo_feedback_echo_core. Stereo frames and
// register writes are driven through the stream and config ports, each echoed
// frame is predicted from a local copy of both history buffers and the gain
// registers, and results are compared per channel in arrival order.
// ----------------------------------------------------------------------------
module tb;
  import sfe_pkg::*;

  localparam int DEPTH            = DEPTH_DEF;
  localparam int FRAMES_PER_PHASE = 220;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } stereo_frame_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [FRAME_W-1:0]  in_tdata;   // left_in, right_in
  logic                out_tvalid;
  logic                out_tready;
  logic [FRAME_W-1:0]  out_tdata;  // left_out, right_out
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [CFG_DW-1:0]   cfg_wdata;

  // predictor state: registers, history buffers, write pointer
  logic [DELAY_W-1:0]  delay_reg;
  gain_t               fb_reg;
  gain_t               wet_reg;
  gain_t               dry_reg;
  sample_t             left_hist [DEPTH];
  sample_t             right_hist [DEPTH];
  int unsigned         write_pos;

  stereo_frame_t       pending_echoes [$];
  int                  mismatch_count = 0;
  bit                  sender_gaps = 1'b0;
  bit                  receiver_stalls = 1'b0;
  int                  hold_off_left = 0;

  stereo_feedback_echo_core #(.DEPTH(DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // round half up of acc / 2^15 (floor shift)
  function automatic longint round_q15(longint acc);
    return (acc + 64'sd16384) >>> 15;
  endfunction

  function automatic sample_t clip_sample(longint v);
    if (v > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
    if (v < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
    return sample_t'(v);
  endfunction

  // one channel: mixed output, plus the value fed back into history
  function automatic sample_t echo_sample(input sample_t x, input sample_t delayed,
                                          output sample_t stored);
    longint mix;
    mix = longint'(dry_reg) * longint'(x) + longint'(wet_reg) * longint'(delayed);
    stored = clip_sample(longint'(x) + round_q15(longint'(fb_reg) * longint'(delayed)));
    return clip_sample(round_q15(mix));
  endfunction

  function automatic void predict_echo(sample_t left_x, sample_t right_x);
    int unsigned   span;
    int unsigned   read_pos;
    stereo_frame_t echo;
    // clamp the delay to 1 .. DEPTH-1
    span = delay_reg;
    if (span < 1) span = 1;
    if (span > DEPTH - 1) span = DEPTH - 1;
    read_pos = (write_pos + DEPTH - span) % DEPTH;
    echo.left  = echo_sample(left_x, left_hist[read_pos], left_hist[write_pos]);
    echo.right = echo_sample(right_x, right_hist[read_pos], right_hist[write_pos]);
    write_pos = (write_pos + 1) % DEPTH;
    pending_echoes.push_back(echo);
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------

  // idle length: mostly short, now and then long
  function automatic int pick_gap();
    if ($urandom_range(0, 15) == 0) return int'($urandom_range(15, 60));
    return int'($urandom_range(1, 3));
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return sample_t'(int'($urandom_range(0, 200)) - 100);
      default: return sample_t'($urandom());
    endcase
  endfunction

  // mostly short delays so the echo actually reads back written data
  function automatic logic [CFG_DW-1:0] random_delay();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_DW'(DEPTH - 1);
      2:       return CFG_DW'($urandom_range(49, 3000));
      3:       return CFG_DW'($urandom());
      default: return CFG_DW'($urandom_range(1, 48));
    endcase
  endfunction

  // upper bits beyond the gain width are written too and must be dropped
  function automatic logic [CFG_DW-1:0] random_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_DW'(32767);
      2:       return '1;
      default: return CFG_DW'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // offer one frame, hold until the request is taken
  task automatic send_frame(sample_t left_x, sample_t right_x);
    int gap;
    gap = (sender_gaps && $urandom_range(0, 9) < 3) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {right_x, left_x};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_echo(left_x, right_x);
  endtask

  // drop valid, drain all outstanding results, then let the pipeline empty
  task automatic settle_block();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_echoes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] value);
    settle_block();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_DELAY_LENGTH:  delay_reg = value[DELAY_W-1:0];
      REG_FEEDBACK_GAIN: fb_reg    = value[GAIN_W-1:0];
      REG_WET_GAIN:      wet_reg   = value[GAIN_W-1:0];
      REG_DRY_GAIN:      dry_reg   = value[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_echo(logic [CFG_DW-1:0] delay, logic [CFG_DW-1:0] fb,
                          logic [CFG_DW-1:0] wet, logic [CFG_DW-1:0] dry);
    write_reg(REG_DELAY_LENGTH, delay);
    write_reg(REG_FEEDBACK_GAIN, fb);
    write_reg(REG_WET_GAIN, wet);
    write_reg(REG_DRY_GAIN, dry);
  endtask

  // receiver: random stalls, plus a long counted hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_tready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready = 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 9) < 3) begin
        stall_left = pick_gap() - 1;
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    stereo_frame_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_echoes.size() == 0) begin
        $error("result frame with nothing expected: %h", out_tdata);
        mismatch_count++;
      end else begin
        want = pending_echoes.pop_front();
        if (out_tdata[SAMPLE_W-1:0] !== want.left) begin
          $error("left_out: expected %0d, got %0d", want.left,
                 $signed(out_tdata[SAMPLE_W-1:0]));
          mismatch_count++;
        end
        if (out_tdata[2*SAMPLE_W-1:SAMPLE_W] !== want.right) begin
          $error("right_out: expected %0d, got %0d", want.right,
                 $signed(out_tdata[2*SAMPLE_W-1:SAMPLE_W]));
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset register values; history reads as zero
  task automatic test_default_settings();
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame(24'sd0, -24'sd1);
    send_frame(24'sd1, 24'sd0);
  endtask

  // delay of zero acts as one; full gains drive output and history into clipping
  task automatic test_short_delay();
    set_echo('0, '1, CFG_DW'(32767), CFG_DW'(32767));
    repeat (3) send_frame(SAMPLE_MAX, SAMPLE_MIN);
    repeat (2) send_frame(SAMPLE_MIN, SAMPLE_MAX);
  endtask

  // zero and half gains (rounding ties), longest delay, dry muted
  task automatic test_gain_extremes();
    set_echo(CFG_DW'(1), CFG_DW'(17'h18000), '0, CFG_DW'(16384));
    send_frame(24'sd1, -24'sd1);
    send_frame(24'sd3, -24'sd3);
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    set_echo(CFG_DW'(DEPTH - 1), CFG_DW'(16384), CFG_DW'(32767), CFG_DW'(32767));
    repeat (3) send_frame(random_sample(), random_sample());
    set_echo(CFG_DW'(2), CFG_DW'(32767), CFG_DW'(32767), '0);
    repeat (3) send_frame(random_sample(), random_sample());
  endtask

  // random settings per phase, one phase without any idling
  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      set_echo(random_delay(), random_gain(), random_gain(), random_gain());
      sender_gaps     = (phase != 2);
      receiver_stalls = (phase != 2);
      repeat (FRAMES_PER_PHASE) send_frame(random_sample(), random_sample());
    end
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  // receiver holds off long while frames keep coming, so the input stalls
  task automatic test_output_backpressure();
    set_echo(CFG_DW'(3), random_gain(), random_gain(), random_gain());
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    hold_off_left   = 150;
    repeat (40) send_frame(random_sample(), random_sample());
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    delay_reg = DELAY_W'(DELAY_RST);
    fb_reg    = FB_RST;
    wet_reg   = WET_RST;
    dry_reg   = DRY_RST;
    write_pos = 0;
    foreach (left_hist[i]) begin
      left_hist[i]  = '0;
      right_hist[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n           = 1'b1;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;

    test_default_settings();
    test_short_delay();
    test_gain_extremes();
    test_random_traffic();
    test_output_backpressure();

    settle_block();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
